[rtl/stpm_pkg.sv]
// ----------------------------------------------------------------------------
// stpm_pkg
// Shared types, widths, register indexes and the square root step for the
// moon disc and terminator pixel mask.
// ----------------------------------------------------------------------------
package stpm_pkg;

  localparam int COORD_BITS    = 10;
  localparam int VEC_FRAC_BITS = 15;

  localparam int CB = COORD_BITS;
  localparam int F  = VEC_FRAC_BITS;

  // port field widths
  localparam int PIX_W       = 10;
  localparam int PHASE_W     = 17;
  localparam int BOX_W       = 10;
  localparam int CFG_DATA_W  = 17;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_LEFT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_TOP    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_WIDTH  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_HEIGHT = 3'd4;

  localparam logic [PHASE_W-1:0] PHASE_RST      = 17'd0;
  localparam logic [BOX_W-1:0]   BOX_LEFT_RST   = 10'd100;
  localparam logic [BOX_W-1:0]   BOX_TOP_RST    = 10'd50;
  localparam logic [BOX_W-1:0]   BOX_WIDTH_RST  = 10'd400;
  localparam logic [BOX_W-1:0]   BOX_HEIGHT_RST = 10'd400;

  localparam logic [PHASE_W-1:0] PHASE_FULL = 17'd65536;
  localparam logic [PHASE_W-1:0] PHASE_HALF = 17'd32768;

  // datapath widths
  localparam int VEC_W  = F + 2;            // signed, magnitude up to 2^F
  localparam int DX_W   = CB + 2;           // signed offset from center
  localparam int DX2_W  = 2 * CB + 2;       // dx^2
  localparam int D2_W   = DX2_W + 1;        // dx^2 + dy^2
  localparam int R_W    = CB - 1;
  localparam int R2_W   = 2 * R_W;
  localparam int Z_SHIFT = 16;              // z carries 8 fraction bits
  localparam int Z_N    = CB + 7;           // root bits of z
  localparam int ZR_W   = Z_N;
  localparam int SQ_N   = (Z_N > F + 1) ? Z_N : F + 1;
  localparam int SQ_W   = 2 * SQ_N;
  localparam int REM_W  = SQ_N + 3;
  localparam int CNT_W  = $clog2(SQ_N);
  localparam int A_W    = DX_W + VEC_W;
  localparam int B_W    = ZR_W + 1 + VEC_W;
  localparam int DOT_W  = CB + F + 13;

  // sun vector scaling
  localparam int COS_UP  = (F >= 15) ? F - 15 : 0;
  localparam int COS_DN  = (F < 15) ? 15 - F : 0;
  localparam int PROD_UP = (2 * F >= 30) ? 2 * F - 30 : 0;
  localparam int PROD_DN = (2 * F < 30) ? 30 - 2 * F : 0;

  typedef logic signed [VEC_W-1:0] vec_t;

  // phase 0: cos = -1, sin = 0
  localparam vec_t COS_RST = vec_t'(-(longint'(1) << F));
  localparam vec_t SIN_RST = vec_t'(0);

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic in_disc;
    logic shadowed;
  } pix_out_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [SQ_N-1:0]  q;
    logic [SQ_W-1:0]  v;
  } sq_t;

  typedef struct packed {
    logic                   in_disc;
    logic signed [DX_W-1:0] dx;
  } zs_tag_t;

  // one digit of a restoring integer square root
  function automatic sq_t sqrt_step(input sq_t s);
    sq_t             o;
    logic [REM_W-1:0] rt;
    logic [REM_W-1:0] tr;
    rt  = {s.rem[REM_W-3:0], s.v[SQ_W-1 -: 2]};
    tr  = {1'b0, s.q, 2'b01};
    o.v = {s.v[SQ_W-3:0], 2'b00};
    if (rt >= tr) begin
      o.rem = rt - tr;
      o.q   = {s.q[SQ_N-2:0], 1'b1};
    end else begin
      o.rem = rt;
      o.q   = {s.q[SQ_N-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

[rtl/stpm_sun.sv]
// ----------------------------------------------------------------------------
// stpm_sun
// Derives the sun vector (sin, cos) from the lunar phase with a single
// multiplier and a bit-serial square root.
// ----------------------------------------------------------------------------
module stpm_sun import stpm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [PHASE_W-1:0] phase,
  output vec_t               sun_sin,
  output vec_t               sun_cos,
  output logic               busy
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FRAC = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_LOAD = 3'd3;
  localparam logic [2:0] ST_ROOT = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]           state;
  logic [PHASE_W-1:0]   f;
  logic                 sin_neg;
  logic [2*PHASE_W-1:0] prod;
  sq_t                  sq;
  logic [CNT_W-1:0]     cnt;

  logic [PHASE_W-1:0]   p_sat;
  logic [PHASE_W-1:0]   ph_off;
  logic [PHASE_W-1:0]   f_next;
  logic [PHASE_W-1:0]   f_comp;
  logic [PHASE_W-1:0]   cmag;
  vec_t                 cmag_s;
  vec_t                 smag_s;
  logic [SQ_W-1:0]      root_in;

  always_comb begin
    p_sat  = (phase > PHASE_FULL) ? PHASE_FULL : phase;
    ph_off = (p_sat >= PHASE_HALF) ? p_sat - PHASE_HALF : PHASE_HALF - p_sat;
    f_next = PHASE_FULL - {ph_off[PHASE_W-2:0], 1'b0};
    f_comp = PHASE_FULL - f;
    cmag   = (f >= PHASE_HALF) ? f - PHASE_HALF : PHASE_HALF - f;
    if (F >= 15) begin
      cmag_s = vec_t'(VEC_W'(cmag) << COS_UP);
    end else begin
      cmag_s = vec_t'(VEC_W'(cmag >> COS_DN));
    end
    if (2 * F >= 30) begin
      root_in = SQ_W'(prod) << PROD_UP;
    end else begin
      root_in = SQ_W'(prod >> PROD_DN);
    end
    smag_s = vec_t'(VEC_W'(sq.q));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      sun_sin <= SIN_RST;
      sun_cos <= COS_RST;
      cnt     <= '0;
    end else if (start) begin
      state <= ST_FRAC;
    end else begin
      case (state)
        ST_IDLE: begin
          state <= ST_IDLE;
        end
        ST_FRAC: begin
          f       <= f_next;
          sin_neg <= (p_sat >= PHASE_HALF);
          state   <= ST_MUL;
        end
        ST_MUL: begin
          prod    <= f * f_comp;
          sun_cos <= (f < PHASE_HALF) ? -cmag_s : cmag_s;
          state   <= ST_LOAD;
        end
        ST_LOAD: begin
          sq.rem <= '0;
          sq.q   <= '0;
          sq.v   <= root_in;
          cnt    <= '0;
          state  <= ST_ROOT;
        end
        ST_ROOT: begin
          sq  <= sqrt_step(sq);
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(SQ_N - 1)) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          sun_sin <= sin_neg ? -smag_s : smag_s;
          state   <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

[rtl/stpm_zsqrt.sv]
// ----------------------------------------------------------------------------
// stpm_zsqrt
// Pipelined square root for the surface height z, one root bit per stage,
// with the pixel tag carried alongside.
// ----------------------------------------------------------------------------
module stpm_zsqrt import stpm_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vld_in,
  input  logic [R2_W-1:0] diff,
  input  zs_tag_t         tag_in,
  output logic            vld_out,
  output logic [ZR_W-1:0] root,
  output zs_tag_t         tag_out
);

  sq_t             st  [SQ_N];
  zs_tag_t         tg  [SQ_N];
  logic [SQ_N-1:0] vld;
  sq_t             seed;

  // operand is (r^2 - d^2) << 16
  assign seed.rem = '0;
  assign seed.q   = '0;
  assign seed.v   = SQ_W'({diff, {Z_SHIFT{1'b0}}});

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= sqrt_step(seed);
      tg[0] <= tag_in;
      for (int i = 1; i < SQ_N; i++) begin
        st[i] <= sqrt_step(st[i-1]);
        tg[i] <= tg[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[SQ_N-2:0], vld_in};
    end
  end

  assign vld_out = vld[SQ_N-1];
  assign root    = st[SQ_N-1].q[ZR_W-1:0];
  assign tag_out = tg[SQ_N-1];

endmodule

[rtl/sphere_terminator_pixel_mask.sv]
// ----------------------------------------------------------------------------
// sphere_terminator_pixel_mask
// Moon disc and terminator test for one pixel per clock while px_stall is low.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock while px_stall is low and returns one result
// beat per pixel, in order, after the 17-stage square root pipeline for z and
// the stages around it. An output register backed by a one-beat skid stage
// lets a pixel enter while a finished result waits. A configuration write
// holds px_stall high for that cycle and, for an index up to REG_BOX_HEIGHT,
// while the sun vector is rebuilt by a bit-serial square root;
// write configuration only with no pixels in flight.
module sphere_terminator_pixel_mask import stpm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   px_valid,
  output logic                   px_stall,
  input  pix_in_t                px_data,
  output logic                   res_valid,
  input  logic                   res_stall,
  output pix_out_t               res_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration
  logic [PHASE_W-1:0] phase;
  logic [BOX_W-1:0]   box_left;
  logic [BOX_W-1:0]   box_top;
  logic [BOX_W-1:0]   box_width;
  logic [BOX_W-1:0]   box_height;
  logic               cfg_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PHASE_RST;
      box_left   <= BOX_LEFT_RST;
      box_top    <= BOX_TOP_RST;
      box_width  <= BOX_WIDTH_RST;
      box_height <= BOX_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE:      phase      <= cfg_data;
        REG_BOX_LEFT:   box_left   <= cfg_data[BOX_W-1:0];
        REG_BOX_TOP:    box_top    <= cfg_data[BOX_W-1:0];
        REG_BOX_WIDTH:  box_width  <= cfg_data[BOX_W-1:0];
        REG_BOX_HEIGHT: box_height <= cfg_data[BOX_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_start = cfg_we && (cfg_index inside {[REG_PHASE:REG_BOX_HEIGHT]});

  vec_t sun_sin;
  vec_t sun_cos;
  logic sun_busy;

  stpm_sun u_sun (
    .clk     (clk),
    .rst     (rst),
    .start   (cfg_start),
    .phase   (phase),
    .sun_sin (sun_sin),
    .sun_cos (sun_cos),
    .busy    (sun_busy)
  );

  // pipeline control
  logic skid_full;
  logic en;
  logic px_take;

  assign en       = !skid_full;
  assign px_stall = skid_full || sun_busy || cfg_we;
  assign px_take  = px_valid && !px_stall;

  // disc geometry
  logic [CB-1:0]   left_c, top_c, w_c, h_c, x_c, y_c;
  logic [CB:0]     cx, cy;
  logic [R_W-1:0]  r_c;
  logic [R2_W-1:0] r2;

  always_comb begin
    left_c = CB'(box_left);
    top_c  = CB'(box_top);
    w_c    = CB'(box_width);
    h_c    = CB'(box_height);
    x_c    = CB'(px_data.pixel_x);
    y_c    = CB'(px_data.pixel_y);
    cx     = {1'b0, left_c} + {2'b00, w_c[CB-1:1]};
    cy     = {1'b0, top_c} + {2'b00, h_c[CB-1:1]};
    r_c    = w_c[CB-1:1];
  end

  always_ff @(posedge clk) begin
    r2 <= r_c * r_c;
  end

  // stage 1: offsets from the center
  logic                   s1_vld;
  logic signed [DX_W-1:0] s1_dx, s1_dy;

  // stage 2: squares
  logic                   s2_vld;
  logic signed [DX_W-1:0] s2_dx;
  logic [DX2_W-1:0]       s2_dx2, s2_dy2;
  logic signed [2*DX_W-1:0] dxx, dyy;

  // stage 3: disc test and root operand
  logic                   s3_vld;
  logic [R2_W-1:0]        s3_diff;
  zs_tag_t                s3_tag;
  logic [D2_W-1:0]        d2;
  logic [D2_W-1:0]        r2_x;
  logic                   in_disc_c;

  assign dxx       = s1_dx * s1_dx;
  assign dyy       = s1_dy * s1_dy;
  assign d2        = {1'b0, s2_dx2} + {1'b0, s2_dy2};
  assign r2_x      = D2_W'(r2);
  assign in_disc_c = (d2 <= r2_x);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx          <= $signed({2'b00, x_c}) - $signed({1'b0, cx});
      s1_dy          <= $signed({2'b00, y_c}) - $signed({1'b0, cy});
      s2_dx          <= s1_dx;
      s2_dx2         <= dxx[DX2_W-1:0];
      s2_dy2         <= dyy[DX2_W-1:0];
      s3_tag.dx      <= s2_dx;
      s3_tag.in_disc <= in_disc_c;
      // off-disc pixels take a zero operand; their shadow bit is masked
      s3_diff        <= in_disc_c ? R2_W'(r2_x - d2) : '0;
    end
  end

  // stages 4 .. SQ_N+3: z = sqrt((r^2 - d^2) << 16)
  logic            z_vld;
  logic [ZR_W-1:0] z_root;
  zs_tag_t         z_tag;

  stpm_zsqrt u_zsqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (s3_vld),
    .diff    (s3_diff),
    .tag_in  (s3_tag),
    .vld_out (z_vld),
    .root    (z_root),
    .tag_out (z_tag)
  );

  // multiply stage
  logic                  s4_vld;
  logic                  s4_in_disc;
  logic signed [A_W-1:0] s4_a;
  logic signed [B_W-1:0] s4_b;
  logic signed [ZR_W:0]  z_s;

  assign z_s = $signed({1'b0, z_root});

  always_ff @(posedge clk) begin
    if (en) begin
      s4_in_disc <= z_tag.in_disc;
      s4_a       <= z_tag.dx * sun_sin;
      s4_b       <= z_s * sun_cos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= px_take;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= z_vld;
    end
  end

  // dot = dx*256*sin + z*cos
  logic signed [DOT_W-1:0] dot;
  pix_out_t                res_next;

  assign dot               = (DOT_W'(s4_a) <<< 8) + DOT_W'(s4_b);
  assign res_next.in_disc  = s4_in_disc;
  assign res_next.shadowed = s4_in_disc && (dot <= 0);

  // output register with one-beat skid
  pix_out_t skid_data;
  logic     out_free;
  logic     res_move;

  assign out_free = !res_valid || !res_stall;
  assign res_move = en && s4_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (out_free) begin
      if (skid_full) begin
        res_valid <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        res_valid <= res_move;
      end
    end else if (res_move) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      res_data <= skid_full ? skid_data : res_next;
    end else if (res_move) begin
      skid_data <= res_next;
    end
  end

endmodule

[rtl/stpm_checker.sv]
// ----------------------------------------------------------------------------
// stpm_checker
// Port-level checks for the pixel mask, bound to the top level.
// ----------------------------------------------------------------------------
module stpm_checker import stpm_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   px_stall,
  input logic                   res_valid,
  input logic                   res_stall,
  input pix_out_t               res_data,
  input logic                   cfg_we,
  input logic [CFG_INDEX_W-1:0] cfg_index
);

  // a stalled result beat stays put
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    !rst && res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("result beat changed while stalled");

  // shadow only on the disc
  a_shadow_on_disc: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.in_disc || !res_data.shadowed))
    else $error("shadowed pixel outside the disc");

  // no pixel taken in the cycle of a register write
  a_cfg_stall: assert property (@(posedge clk)
    cfg_we |-> px_stall)
    else $error("pixel accepted during a register write");

  // sun vector rebuild keeps the input closed after a valid write
  a_derive_stall: assert property (@(posedge clk) disable iff (rst)
    !rst && cfg_we && (cfg_index <= REG_BOX_HEIGHT) |=> px_stall)
    else $error("pixel accepted while the sun vector is rebuilt");

endmodule

bind sphere_terminator_pixel_mask stpm_checker u_stpm_checker (
  .clk       (clk),
  .rst       (rst),
  .px_stall  (px_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index)
);
